// ----- hdl/hex_ring_enumerator_macros.svh -----
// ---------------------------------------------------------------------------
// Hex ring enumerator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, held off during reset.
// ---------------------------------------------------------------------------
`ifndef HEX_RING_ENUMERATOR_MACROS_SVH
`define HEX_RING_ENUMERATOR_MACROS_SVH

// Same-cycle implication.
`define HRE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hex ring enumerator: same-cycle check failed");

// Next-cycle implication.
`define HRE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hex ring enumerator: next-cycle check failed");

`endif

// ----- hdl/hre_pkg.sv -----
// ---------------------------------------------------------------------------
// Hex ring enumerator package
// Default board geometry, datapath widths and controller/datapath links.
// ---------------------------------------------------------------------------
`default_nettype none

package hre_pkg;

  localparam int BOARD_WIDTH_DEF  = 17;
  localparam int BOARD_HEIGHT_DEF = 11;
  localparam int MAX_RADIUS_DEF   = 10;

  localparam int CENTER_W = 8;
  localparam int RADIUS_W = 4;
  localparam int CELL_W   = 8;
  // Signed width of the axial coordinate differences.
  localparam int DIST_W   = 10;

  typedef struct packed {
    logic load;
    logic div_step;
    logic scan_step;
    logic flush;
  } hre_cmd_t;

  typedef struct packed {
    logic radius_ok;
    logic div_done;
    logic advance;
    logic scan_end;
    logic flush_done;
    logic pend_valid;
  } hre_sts_t;

endpackage

`default_nettype wire

// ----- hdl/hre_ctrl.sv -----
// ---------------------------------------------------------------------------
// Hex ring enumerator controller
// Sequences load, centre split, board scan and final flush of one request.
// ---------------------------------------------------------------------------
`default_nettype none

module hre_ctrl
  import hre_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire hre_sts_t sts_i,
  output hre_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o           = '0;
    state_d         = state_q;
    cmd_o.load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (!sts_i.radius_ok) begin
          state_d = ST_IDLE;
        end else if (sts_i.div_done) begin
          state_d = ST_SCAN;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.advance && sts_i.scan_end) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (sts_i.flush_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_ready_o <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_o <= (state_d == ST_IDLE);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hre_dp.sv -----
// ---------------------------------------------------------------------------
// Hex ring enumerator datapath
// Centre split, scan counters, hex distance test, look-ahead and output word.
// ---------------------------------------------------------------------------
`default_nettype none

module hre_dp
  import hre_pkg::*;
#(
  parameter int BOARD_WIDTH  = BOARD_WIDTH_DEF,
  parameter int BOARD_HEIGHT = BOARD_HEIGHT_DEF,
  parameter int MAX_RADIUS   = MAX_RADIUS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire hre_cmd_t            cmd_i,
  output hre_sts_t                 sts_o,
  input  wire logic [CENTER_W-1:0] center_hex_i,
  input  wire logic [RADIUS_W-1:0] ring_radius_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [CELL_W-1:0]        cell_index_o,
  output logic                     last_cell_o
);

  localparam int XW    = $clog2(BOARD_WIDTH);
  localparam int YW    = $clog2(BOARD_HEIGHT);
  localparam int NCELL = BOARD_WIDTH * BOARD_HEIGHT;
  localparam int IDXW  = ($clog2(NCELL) > CELL_W) ? $clog2(NCELL) : CELL_W;

  logic [CENTER_W-1:0] rem_q;
  logic [CENTER_W-1:0] cy_q;
  logic [RADIUS_W-1:0] radius_q;
  logic                radius_ok_q;
  logic [XW-1:0]       x_q;
  logic [YW-1:0]       y_q;
  logic [IDXW-1:0]     cell_q;
  logic                pend_valid_q;
  logic [CELL_W-1:0]   pend_idx_q;
  logic                out_valid_q;
  logic [CELL_W-1:0]   out_idx_q;
  logic                out_last_q;

  function automatic logic [DIST_W-1:0] abs_val(input logic [DIST_W-1:0] a);
    abs_val = a[DIST_W-1] ? (~a + DIST_W'(1)) : a;
  endfunction

  logic [DIST_W-1:0] xz, yz, cxz, cyz;
  logic [DIST_W-1:0] q_cell, q_cent, dq, dr, ds;
  logic [DIST_W:0]   dsum;
  logic              match;
  logic              out_free;
  logic              scan_push;
  logic              flush_push;

  // Axial q = x - (y + 1) / 2; rows and columns are never negative here.
  always_comb begin
    xz     = {{(DIST_W-XW){1'b0}}, x_q};
    yz     = {{(DIST_W-YW){1'b0}}, y_q};
    cxz    = {{(DIST_W-CENTER_W){1'b0}}, rem_q};
    cyz    = {{(DIST_W-CENTER_W){1'b0}}, cy_q};
    q_cell = xz - ((yz + DIST_W'(1)) >> 1);
    q_cent = cxz - ((cyz + DIST_W'(1)) >> 1);
    dq     = q_cell - q_cent;
    dr     = yz - cyz;
    ds     = dq + dr;
    dsum   = {1'b0, abs_val(dq)} + {1'b0, abs_val(dr)} + {1'b0, abs_val(ds)};
    match  = (dsum[DIST_W:1] == {{(DIST_W-RADIUS_W){1'b0}}, radius_q});
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign scan_push  = cmd_i.scan_step && match && pend_valid_q && out_free;
  assign flush_push = cmd_i.flush && pend_valid_q && out_free;

  always_comb begin
    sts_o            = '0;
    sts_o.radius_ok  = radius_ok_q;
    sts_o.div_done   = (rem_q < CENTER_W'(BOARD_WIDTH));
    sts_o.advance    = !(match && pend_valid_q) || out_free;
    sts_o.scan_end   = (x_q == XW'(BOARD_WIDTH - 1)) && (y_q == YW'(BOARD_HEIGHT - 1));
    sts_o.flush_done = !pend_valid_q || out_free;
    sts_o.pend_valid = pend_valid_q;
  end

  // Request registers and scan counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      cy_q        <= '0;
      radius_q    <= '0;
      radius_ok_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      cell_q      <= '0;
    end else if (cmd_i.load) begin
      rem_q       <= center_hex_i;
      cy_q        <= '0;
      radius_q    <= ring_radius_i;
      radius_ok_q <= (ring_radius_i <= RADIUS_W'(MAX_RADIUS));
      x_q         <= '0;
      y_q         <= '0;
      cell_q      <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_q - CENTER_W'(BOARD_WIDTH);
      cy_q  <= cy_q + CENTER_W'(1);
    end else if (cmd_i.scan_step && sts_o.advance) begin
      cell_q <= cell_q + IDXW'(1);
      if (x_q == XW'(BOARD_WIDTH - 1)) begin
        x_q <= '0;
        y_q <= y_q + YW'(1);
      end else begin
        x_q <= x_q + XW'(1);
      end
    end
  end

  // Hold one match back so that the final one can carry the mark.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.scan_step && match && sts_o.advance) begin
        pend_valid_q <= 1'b1;
      end else if (flush_push) begin
        pend_valid_q <= 1'b0;
      end
      if (scan_push || flush_push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && match && sts_o.advance) begin
      pend_idx_q <= cell_q[CELL_W-1:0];
    end
    if (scan_push || flush_push) begin
      out_idx_q  <= pend_idx_q;
      out_last_q <= flush_push;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_index_o = out_idx_q;
  assign last_cell_o  = out_last_q;

endmodule

`default_nettype wire

// ----- hdl/hex_ring_enumerator.sv -----
// Sequence: a load, a centre split by repeated subtraction of BOARD_WIDTH, then a scan
//   of one board cell per cycle while no match waits on a held output word; a held
//   match moves into the output word register when the next match is found. A radius
//   above MAX_RADIUS ends the request without a scan. New requests are taken only in idle.
// Reset: rst_ni is asynchronous, active low; it returns the controller to idle
//   and drops all pending and output words.
// ---------------------------------------------------------------------------
// Hex ring enumerator
// Emits, in ascending index order, every on-board cell at an exact hex
// distance (at most MAX_RADIUS) from a centre cell, marking the final cell of the ring.
// ---------------------------------------------------------------------------
`default_nettype none

`include "hex_ring_enumerator_macros.svh"

module hex_ring_enumerator
  import hre_pkg::*;
#(
  parameter int BOARD_WIDTH  = BOARD_WIDTH_DEF,
  parameter int BOARD_HEIGHT = BOARD_HEIGHT_DEF,
  parameter int MAX_RADIUS   = MAX_RADIUS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request words.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [7:0] center_hex, [11:8] ring_radius, [15:12] zero
  // Result words.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] cell_index
  output logic             m_axis_tlast_o    // last_cell
);

  hre_cmd_t cmd;
  hre_sts_t sts;

  // The controller only ever sees status; all arithmetic lives in the datapath.
  hre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Centre split by repeated subtraction, a scan of every cell with one distance
  // test per cycle unless a match waits on a held output word, a single match
  // held back for the last mark, and an output word register that decouples the sink.
  hre_dp #(
    .BOARD_WIDTH  (BOARD_WIDTH),
    .BOARD_HEIGHT (BOARD_HEIGHT),
    .MAX_RADIUS   (MAX_RADIUS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .center_hex_i  (s_axis_tdata_i[7:0]),
    .ring_radius_i (s_axis_tdata_i[11:8]),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .cell_index_o  (m_axis_tdata_o),
    .last_cell_o   (m_axis_tlast_o)
  );

  // The scan may only stall when the output word is held by the sink.
  `HRE_ASSERT_NOW(a_stall_cause, cmd.scan_step && !sts.advance, m_axis_tvalid_o && !m_axis_tready_i)
  // No held-back match may survive into idle.
  `HRE_ASSERT_NOW(a_idle_no_pend, s_axis_tready_o, !sts.pend_valid)
  // A flush that hands over its word leaves nothing pending.
  `HRE_ASSERT_NEXT(a_flush_clears, cmd.flush && sts.flush_done, !sts.pend_valid)

endmodule

`default_nettype wire

// ----- test/hex_ring_enumerator_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hex ring enumerator testbench
// Drives centre/radius request words into the block and checks every result
// word against a ring predictor kept in a small scoreboard. The run covers
// board corners and edges, odd and even rows, the smallest and largest radii,
// ignored radii and centres that lie off the board. Both sides idle at random.
// The receiver holds off once for a long stretch. The sender drains once.
// ---------------------------------------------------------------------------

class ring_scoreboard;

  typedef struct packed {
    logic [7:0] cell_idx;
    logic       last;
  } ring_cell_t;

  localparam int BoardW   = hre_pkg::BOARD_WIDTH_DEF;
  localparam int BoardH   = hre_pkg::BOARD_HEIGHT_DEF;
  localparam int MaxRad   = hre_pkg::MAX_RADIUS_DEF;
  localparam int HexSides = 6;

  ring_cell_t pending_cells[$];
  bit [7:0]   held_centre;
  bit [3:0]   held_radius;
  int         mismatches;
  int         requests_noted;
  int         cells_checked;
  int         offboard_requests;
  int         ignored_requests;
  int         empty_rings;

  // Work out the ring for one accepted request and queue its cells.
  function void note_request(bit [7:0] centre, bit [3:0] radius);
    int         cx, cy, cq, x, y, dq, dr, hex_dist, found;
    ring_cell_t entry;
    held_centre = centre;
    held_radius = radius;
    requests_noted++;
    if (int'(centre) >= BoardW * BoardH) offboard_requests++;
    if (int'(radius) > MaxRad) begin
      ignored_requests++;
      return;
    end
    found = 0;
    cx = int'(centre) % BoardW;
    cy = int'(centre) / BoardW;
    cq = cx - (cy + 1) / 2;
    for (int pos = 0; pos < BoardW * BoardH; pos++) begin
      x        = pos % BoardW;
      y        = pos / BoardW;
      dq       = (x - (y + 1) / 2) - cq;
      dr       = y - cy;
      hex_dist = ((dq < 0 ? -dq : dq) + (dr < 0 ? -dr : dr) +
                  ((dq + dr) < 0 ? -(dq + dr) : (dq + dr))) / 2;
      if (hex_dist != int'(radius)) continue;
      if (found >= HexSides * MaxRad) break;
      entry.cell_idx = pos[7:0];
      entry.last     = 1'b0;
      pending_cells.insert(pending_cells.size(), entry);
      found++;
    end
    // Mark the final cell of a non-empty ring.
    if (found > 0) pending_cells[pending_cells.size() - 1].last = 1'b1;
    else empty_rings++;
  endfunction

  // Compare one accepted result word with the oldest queued cell.
  function void check_cell(logic [7:0] got_idx, logic last);
    ring_cell_t want;
    cells_checked++;
    if (pending_cells.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result word cell=%0d last=%0b", $realtime, got_idx, last);
      return;
    end
    want = pending_cells.pop_front();
    if (got_idx !== want.cell_idx || last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result mismatch: expected cell=%0d last=%0b, got cell=%0d last=%0b",
                 $realtime, want.cell_idx, want.last, got_idx, last);
    end
  endfunction

  function int outstanding();
    return pending_cells.size();
  endfunction

endclass

module hex_ring_enumerator_test;

  localparam int BoardCells  = hre_pkg::BOARD_WIDTH_DEF * hre_pkg::BOARD_HEIGHT_DEF;
  localparam int MaxRadius   = hre_pkg::MAX_RADIUS_DEF;
  localparam int RandomItems = 140;
  // One full scan plus the centre split, with margin, for the tail wait.
  localparam int DrainCycles = 300;
  localparam int HoldCycles  = 1500;
  localparam int CycleLimit  = 800000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;   // [7:0] center_hex, [11:8] ring_radius, [15:12] zero
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;   // [7:0] cell_index
  logic        m_axis_tlast_o;   // last_cell

  ring_scoreboard sb;
  int             cycle_count;
  bit             long_hold_done;

  hex_ring_enumerator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Abort a run that hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check every result word accepted at a rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_cell(m_axis_tdata_o, m_axis_tlast_o);
  end

  // Offer one request word after a random gap (none with no_gap); note it once accepted.
  task automatic send_request(input bit [7:0] centre, input bit [3:0] radius,
                              input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {4'b0000, radius, centre};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(centre, radius);
    @(negedge clk_i);
  endtask

  // Receiver: random back-pressure per word, one long hold-off early on,
  // and a stretch of full-rate acceptance in the middle.
  initial begin
    int gap;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!long_hold_done && sb.cells_checked >= 30) begin
        // Hold off long enough for the block to back up into its input.
        long_hold_done  = 1'b1;
        m_axis_tready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (sb.cells_checked >= 400 && sb.cells_checked < 700) gap = 0;
      else gap = $urandom_range(0, 3);
      if (gap > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    bit [7:0] centre;
    bit [3:0] radius;
    int       useful;
    int       item;

    sb              = new();
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed requests: corners, edges, odd rows, radius extremes,
    // ignored radii and centres off the board.
    send_request(8'd0,   4'd0,  1'b0);  // top-left corner, centre only
    send_request(8'd186, 4'd0,  1'b0);  // bottom-right corner, centre only
    send_request(8'd93,  4'd0,  1'b0);  // middle of the board
    send_request(8'd93,  4'd1,  1'b0);
    send_request(8'd93,  4'd5,  1'b0);
    send_request(8'd93,  4'd10, 1'b0);  // largest ring
    send_request(8'd0,   4'd10, 1'b0);
    send_request(8'd186, 4'd10, 1'b0);
    send_request(8'd16,  4'd5,  1'b0);  // top-right corner
    send_request(8'd170, 4'd5,  1'b0);  // bottom-left corner
    send_request(8'd17,  4'd1,  1'b0);  // odd row, left edge
    send_request(8'd33,  4'd2,  1'b0);  // odd row, right edge
    send_request(8'd50,  4'd3,  1'b0);  // even row, right edge
    send_request(8'd93,  4'd11, 1'b0);  // radius just past the maximum
    send_request(8'd0,   4'd15, 1'b0);  // widest radius code
    send_request(8'd187, 4'd0,  1'b0);  // first index off the board
    send_request(8'd200, 4'd2,  1'b0);  // off board, ring reaches back on
    send_request(8'd255, 4'd3,  1'b0);  // ring wholly off the board
    send_request(8'd255, 4'd10, 1'b0);
    send_request(8'd255, 4'd15, 1'b0);  // all input bits high
    send_request(8'd170, 4'd1,  1'b0);

    // Random requests: mostly on-board centres with legal radii.
    useful = 0;
    item   = 0;
    while (useful < RandomItems) begin
      if ($urandom_range(0, 9) < 8) begin
        centre = 8'($urandom_range(0, BoardCells - 1));
        radius = 4'($urandom_range(0, MaxRadius));
      end else begin
        centre = 8'($urandom_range(0, 255));
        radius = 4'($urandom_range(0, 15));
      end
      if (item == 100) begin
        // Drain completely before going on.
        s_axis_tvalid_i = 1'b0;
        while (sb.outstanding() != 0) @(negedge clk_i);
      end
      send_request(centre, radius, item >= 60 && item < 80);
      if (int'(radius) <= MaxRadius) useful++;
      item++;
    end
    s_axis_tvalid_i = 1'b0;

    // Wait for the queued cells, then watch for stray words.
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Covered %0d requests (%0d off-board centres, %0d ignored radii, %0d empty rings),",
             sb.requests_noted, sb.offboard_requests, sb.ignored_requests, sb.empty_rings);
    $display("checked %0d result words with %0d mismatches.", sb.cells_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
